### rtl/assert_macros.svh
// Assertion macros used by the controller of the name hash id map.
// Depends on nothing; synthesis builds define SYNTHESIS so the bodies vanish.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while the active-low reset is applied.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while the active-low reset is applied.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/nhim_pkg.sv
// Package for the name hash id map: sizes, codes, word types and the
// controller/datapath interface structs. Depends on nothing.
package nhim_pkg;

    localparam int ENTRY_DEPTH = 32;
    localparam int MAP_DEPTH   = 64;
    localparam int NUM_BANKS   = 3;

    localparam int SLOT_W      = $clog2(MAP_DEPTH);
    localparam int MAP_ADDR_W  = $clog2(NUM_BANKS * MAP_DEPTH);
    localparam int ENT_ADDR_W  = $clog2(NUM_BANKS * ENTRY_DEPTH);

    localparam logic [31:0] HASH_INIT   = 32'd5381;
    localparam logic [7:0]  SLOT_EMPTY  = 8'hFF;
    localparam logic [7:0]  CASE_OFFSET = 8'd32;
    localparam logic [7:0]  CHAR_LOW_A  = 8'h61;
    localparam logic [7:0]  CHAR_LOW_Z  = 8'h7A;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic       req_type;
        logic [1:0] table_sel;
        logic [7:0] name_char;
        logic       last_char;
        logic [4:0] entry_index;
        logic [7:0] entry_id;
    } t_req_word;

    typedef struct packed {
        t_status    status;
        logic [7:0] found_id;
    } t_result_word;

    typedef struct packed {
        logic accept;    // input word taken this cycle
        logic ent_wr;    // store hash and id at the request's entry
        logic map_wr;    // point the current map slot at the request's entry
        logic slot_adv;  // move the probe to the next slot
    } t_dp_cmd;

    typedef struct packed {
        logic       req_type;
        logic       bank_bad;
        logic       idx_bad;
        logic       slot_free;
        logic       map_in_range;
        logic       hash_match;
        logic       last_probe;
        logic [7:0] found_val;
    } t_dp_sts;

endpackage

### rtl/nhim_dp.sv
// Datapath of the name hash id map: running hash, request registers, probe
// slot and the probe map and entry memories. Depends on nhim_pkg.
module nhim_dp
    import nhim_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_req_word i_item,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts
);

    // Case-folds a letter and folds a nonzero byte into the djb2 hash.
    function automatic logic [31:0] fold_byte(logic [31:0] h, logic [7:0] c);
        logic [7:0] u;
        u = c;
        if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z) begin
            u = c - CASE_OFFSET;
        end
        if (c == 8'd0) begin
            return h;
        end
        return (h << 5) + h + {24'd0, u};
    endfunction

    logic [31:0]           r_hash;
    logic [31:0]           r_req_hash;
    logic [1:0]            r_bank;
    logic                  r_type;
    logic [4:0]            r_idx;
    logic [7:0]            r_id;
    logic [SLOT_W-1:0]     r_slot;
    logic [SLOT_W-1:0]     r_cnt;

    logic [7:0]            r_map_mem [NUM_BANKS*MAP_DEPTH];
    logic [NUM_BANKS*MAP_DEPTH-1:0] r_map_vld;
    logic [7:0]            r_map_q;
    logic                  r_map_vq;

    logic [31:0]           r_ent_hash [NUM_BANKS*ENTRY_DEPTH];
    logic [7:0]            r_ent_val  [NUM_BANKS*ENTRY_DEPTH];
    logic [31:0]           r_eh_q;
    logic [7:0]            r_ev_q;

    logic [31:0]           w_fold;
    logic [MAP_ADDR_W-1:0] w_map_addr;
    logic [ENT_ADDR_W-1:0] w_ent_waddr;
    logic [ENT_ADDR_W-1:0] w_ent_raddr;

    assign w_fold      = fold_byte(r_hash, i_item.name_char);
    assign w_map_addr  = MAP_ADDR_W'(r_bank) * MAP_ADDR_W'(MAP_DEPTH) + MAP_ADDR_W'(r_slot);
    assign w_ent_waddr = ENT_ADDR_W'(r_bank) * ENT_ADDR_W'(ENTRY_DEPTH) + ENT_ADDR_W'(r_idx);
    assign w_ent_raddr = ENT_ADDR_W'(r_bank) * ENT_ADDR_W'(ENTRY_DEPTH) + ENT_ADDR_W'(r_map_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= HASH_INIT;
        end else if (i_cmd.accept) begin
            r_hash <= i_item.last_char ? HASH_INIT : w_fold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_item.last_char) begin
            r_req_hash <= w_fold;
            r_bank     <= i_item.table_sel;
            r_type     <= i_item.req_type;
            r_idx      <= i_item.entry_index;
            r_id       <= i_item.entry_id;
            r_slot     <= w_fold[SLOT_W-1:0];
            r_cnt      <= '0;
        end else if (i_cmd.slot_adv) begin
            r_slot <= r_slot + SLOT_W'(1);
            r_cnt  <= r_cnt + SLOT_W'(1);
        end
    end

    // Probe map store; slots never written read as empty through the valid bits.
    always_ff @(posedge i_clk) begin
        if (i_cmd.map_wr) begin
            r_map_mem[w_map_addr] <= 8'(r_idx);
        end
        r_map_q <= r_map_mem[w_map_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_vld <= '0;
            r_map_vq  <= 1'b0;
        end else begin
            if (i_cmd.map_wr) begin
                r_map_vld[w_map_addr] <= 1'b1;
            end
            r_map_vq <= r_map_vld[w_map_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ent_wr) begin
            r_ent_hash[w_ent_waddr] <= r_req_hash;
            r_ent_val[w_ent_waddr]  <= r_id;
        end
        r_eh_q <= r_ent_hash[w_ent_raddr];
        r_ev_q <= r_ent_val[w_ent_raddr];
    end

    assign o_sts.req_type     = r_type;
    assign o_sts.bank_bad     = 32'(r_bank) >= NUM_BANKS;
    assign o_sts.idx_bad      = 32'(r_idx) >= ENTRY_DEPTH;
    assign o_sts.slot_free    = !r_map_vq || (r_map_q == SLOT_EMPTY);
    assign o_sts.map_in_range = 32'(r_map_q) < ENTRY_DEPTH;
    assign o_sts.hash_match   = r_eh_q == r_req_hash;
    assign o_sts.last_probe   = r_cnt == SLOT_W'(MAP_DEPTH - 1);
    assign o_sts.found_val    = r_ev_q;

endmodule

### rtl/nhim_ctrl.sv
// Controller of the name hash id map: request sequencing, probe walk and the
// result register. Depends on nhim_pkg and assert_macros.svh.
`include "assert_macros.svh"

module nhim_ctrl
    import nhim_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic         i_last,
    input  t_dp_sts      i_sts,
    output t_dp_cmd      o_cmd,
    output logic         o_busy,
    output logic         o_valid,
    output t_result_word o_result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_MAP_RD,
        S_MAP_CHK,
        S_ENT_CHK
    } t_state;

    t_state       r_state;
    t_state       n_state;
    logic         r_valid;
    logic         n_valid;
    t_result_word r_result;
    t_result_word n_result;

    always_comb begin
        n_state  = r_state;
        n_valid  = 1'b0;
        n_result = '{status: ST_NOT_FOUND, found_id: 8'd0};
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_start;
                if (i_start && i_last) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if (i_sts.bank_bad) begin
                    n_valid  = 1'b1;
                    n_state  = S_IDLE;
                end else if (i_sts.req_type == REQ_INSERT && i_sts.idx_bad) begin
                    n_valid         = 1'b1;
                    n_result.status = ST_FULL;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.ent_wr = (i_sts.req_type == REQ_INSERT);
                    n_state      = S_MAP_CHK;
                end
            end
            S_MAP_RD: begin
                n_state = S_MAP_CHK;
            end
            S_MAP_CHK: begin
                if (i_sts.slot_free) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                    if (i_sts.req_type == REQ_INSERT) begin
                        o_cmd.map_wr    = 1'b1;
                        n_result.status = ST_INSERTED;
                    end
                end else if (i_sts.map_in_range) begin
                    n_state = S_ENT_CHK;
                end else begin
                    o_cmd.slot_adv = 1'b1;
                    if (i_sts.last_probe) begin
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                        if (i_sts.req_type == REQ_INSERT) begin
                            n_result.status = ST_FULL;
                        end
                    end else begin
                        n_state = S_MAP_RD;
                    end
                end
            end
            S_ENT_CHK: begin
                if (i_sts.hash_match) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                    if (i_sts.req_type == REQ_INSERT) begin
                        o_cmd.map_wr    = 1'b1;
                        n_result.status = ST_INSERTED;
                    end else begin
                        n_result.status   = ST_FOUND;
                        n_result.found_id = i_sts.found_val;
                    end
                end else begin
                    o_cmd.slot_adv = 1'b1;
                    if (i_sts.last_probe) begin
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                        if (i_sts.req_type == REQ_INSERT) begin
                            n_result.status = ST_FULL;
                        end
                    end else begin
                        n_state = S_MAP_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= 1'b0;
            r_result <= '0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_result <= n_result;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    `ASSERT_IMPL(a_valid_idle, i_clk, i_rst_n, r_valid, r_state == S_IDLE)
    `ASSERT_NEXT(a_last_starts, i_clk, i_rst_n, o_cmd.accept && i_last, r_state == S_START)
    `ASSERT_IMPL(a_map_wr_chk, i_clk, i_rst_n, o_cmd.map_wr, (r_state == S_MAP_CHK) || (r_state == S_ENT_CHK))
    `ASSERT_IMPL(a_id_zero, i_clk, i_rst_n, r_valid && (r_result.status != ST_FOUND), r_result.found_id == 8'd0)

endmodule

### rtl/name_hash_id_map_unit.sv
// Top level of the name hash id map: joins the controller and the datapath.
// Depends on nhim_pkg, nhim_ctrl and nhim_dp.
//
// Usage: a name arrives one byte per word on i_item; a word is taken at a
// rising edge where start is high and busy is low. Each byte is case-folded
// for a to z and folded into a djb2 hash; a zero byte leaves the hash alone.
// Words that are not the last of a name leave busy low, so a name streams in
// at one byte per cycle.
// The word with last_char set starts an insert or a lookup in the bank named
// by table_sel, and busy stays high until the answer is out. The answer is
// shown on o_result for exactly one cycle with o_valid high; the receiver
// cannot hold it off, and the next word may be offered in that same cycle.
// After the last word the answer comes from the start state for the unused
// bank or an insert at an out-of-range entry index, from the map check if the
// home slot is empty, from the entry check if it holds the matching entry; each
// further slot adds a map read, a map check and, if it points at an entry, an
// entry check, as the probe map and the entry store each have one read port.
// Reset clears the running hash and marks every probe map slot empty through
// per-slot valid bits, so no clearing pass is needed and the block is ready
// in the cycle after reset is released. Entry contents are not cleared.
module name_hash_id_map_unit
    import nhim_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    input  t_req_word    i_item,
    output logic         busy,
    output logic         o_valid,
    output t_result_word o_result
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // The controller owns the handshake and the result register.
    nhim_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_last   (i_item.last_char),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // The datapath holds the hash, the request and the memories.
    nhim_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts)
    );

endmodule

### tb/tb_top.sv
// Self-checking testbench for name_hash_id_map_unit: streams names into all banks and
// checks every answer against a behavioral model of the hash map kept in this file.
// Depends on nhim_pkg and the RTL of name_hash_id_map_unit.
`timescale 1ns / 100ps

module tb_top;
    import nhim_pkg::*;

    // Bank codes as carried in table_sel.
    localparam logic [1:0] BANK_DOMAIN = 2'd0;
    localparam logic [1:0] BANK_ENTITY = 2'd1;
    localparam logic [1:0] BANK_LEVEL  = 2'd2;
    localparam logic [1:0] BANK_UNUSED = 2'd3;

    localparam int RANDOM_WORDS = 60;
    localparam int POOL_SIZE    = 24;

    typedef logic [7:0] name_t[$];

    logic         i_clk;
    logic         i_rst_n = 1'b0;
    logic         start   = 1'b0;
    t_req_word    i_item  = '0;
    logic         busy;
    logic         o_valid;
    t_result_word o_result;

    // Model of the block's state: running hash, probe maps and entry stores.
    logic [31:0]  run_hash;
    logic [7:0]   slot_ref   [NUM_BANKS][MAP_DEPTH];
    logic [31:0]  ent_hash_m [NUM_BANKS][ENTRY_DEPTH];
    logic [7:0]   ent_id_m   [NUM_BANKS][ENTRY_DEPTH];

    // Answers the model has worked out and the block has not yet produced.
    t_result_word answer_q[$];

    int words_sent      = 0;
    int answers_checked = 0;
    int err_count       = 0;
    bit gaps_on         = 1'b1;

    name_hash_id_map_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // One djb2 step with a to z folded to upper case; a zero byte leaves the hash alone.
    function automatic logic [31:0] fold_char(input logic [31:0] h, input logic [7:0] c);
        logic [7:0] u;
        if (c == 8'd0)
            return h;
        u = c;
        if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z)
            u = c - CASE_OFFSET;
        return (h << 5) + h + {24'd0, u};
    endfunction

    // Applies one accepted word to the model. The last word of a name runs the
    // insert or lookup and queues the answer the block must give.
    task automatic predict_word(input t_req_word w);
        logic [31:0]  h;
        logic [7:0]   v;
        int           b;
        int           slot;
        int           idx;
        bit           done;
        t_result_word r;
        run_hash = fold_char(run_hash, w.name_char);
        if (!w.last_char)
            return;
        h        = run_hash;
        run_hash = HASH_INIT;
        b        = int'(w.table_sel);
        idx      = int'(w.entry_index);
        slot     = int'(h % 32'(MAP_DEPTH));
        r.status   = ST_NOT_FOUND;
        r.found_id = 8'd0;
        if (b < NUM_BANKS && w.req_type == REQ_INSERT) begin
            if (idx >= ENTRY_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // The entry is written even when no slot can be claimed.
                ent_hash_m[b][idx] = h;
                ent_id_m[b][idx]   = w.entry_id;
                r.status = ST_FULL;
                for (int n = 0; n < MAP_DEPTH && r.status == ST_FULL; n++) begin
                    v = slot_ref[b][slot];
                    if (v == SLOT_EMPTY || (int'(v) < ENTRY_DEPTH && ent_hash_m[b][v] == h)) begin
                        slot_ref[b][slot] = 8'(idx);
                        r.status = ST_INSERTED;
                    end else begin
                        slot = (slot + 1) % MAP_DEPTH;
                    end
                end
            end
        end else if (b < NUM_BANKS) begin
            done = 1'b0;
            for (int n = 0; n < MAP_DEPTH && !done; n++) begin
                v = slot_ref[b][slot];
                if (v == SLOT_EMPTY) begin
                    done = 1'b1;
                end else if (int'(v) < ENTRY_DEPTH && ent_hash_m[b][v] == h) begin
                    r.status   = ST_FOUND;
                    r.found_id = ent_id_m[b][v];
                    done = 1'b1;
                end else begin
                    slot = (slot + 1) % MAP_DEPTH;
                end
            end
        end
        answer_q.push_back(r);
    endtask

    function automatic t_req_word rand_fields();
        t_req_word w;
        w.req_type    = 1'($urandom_range(1));
        w.table_sel   = 2'($urandom_range(3));
        w.name_char   = 8'($urandom_range(255));
        w.last_char   = 1'($urandom_range(1));
        w.entry_index = 5'($urandom_range(31));
        w.entry_id    = 8'($urandom_range(255));
        return w;
    endfunction

    // Offers one word and holds it until the block takes it. Afterwards the
    // sender may drop start and put a random word on i_item; start is only ever
    // lowered in a step where nothing raises it again.
    task automatic send_word(input t_req_word w);
        start  <= 1'b1;
        i_item <= w;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        predict_word(w);
        words_sent++;
        if (gaps_on && $urandom_range(99) < 30) begin
            start  <= 1'b0;
            i_item <= rand_fields();
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
    endtask

    // Streams a name one byte per word. Fields other than name_char and last_char are
    // random on the leading words, as the block only looks at them on the last one.
    task automatic send_name(input logic req, input logic [1:0] bank, input name_t nm,
                             input logic [4:0] idx, input logic [7:0] id);
        t_req_word w;
        name_t     chars;
        chars = nm;
        if (chars.size() == 0)
            chars.push_back(8'd0);
        foreach (chars[k]) begin
            w           = rand_fields();
            w.name_char = chars[k];
            w.last_char = (k == chars.size() - 1);
            if (w.last_char) begin
                w.req_type    = req;
                w.table_sel   = bank;
                w.entry_index = idx;
                w.entry_id    = id;
            end
            send_word(w);
        end
    endtask

    task automatic add_name(input logic [1:0] bank, input name_t nm,
                            input logic [4:0] idx, input logic [7:0] id);
        send_name(REQ_INSERT, bank, nm, idx, id);
    endtask

    task automatic lookup_name(input logic [1:0] bank, input name_t nm);
        send_name(REQ_LOOKUP, bank, nm, 5'($urandom_range(31)), 8'($urandom_range(255)));
    endtask

    // Holds the sender off until every outstanding answer has come back.
    task automatic wait_drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (answer_q.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic name_t to_name(input string s);
        name_t nm;
        foreach (s[k])
            nm.push_back(s[k]);
        return nm;
    endfunction

    // Random name, mostly letters of either case so that folding is exercised.
    function automatic name_t rand_name(input int len);
        name_t nm;
        int    r;
        repeat (len) begin
            r = $urandom_range(25);
            case ($urandom_range(2))
                0: nm.push_back(8'(int'(CHAR_LOW_A) + r));
                1: nm.push_back(8'(int'(CHAR_LOW_A - CASE_OFFSET) + r));
                default: nm.push_back(8'($urandom_range(1, 255)));
            endcase
        end
        return nm;
    endfunction

    // Same name as the block sees it: letters flip case at random and an
    // occasional zero byte is slipped in, neither of which changes the hash.
    function automatic name_t vary_case(input name_t nm);
        name_t      mixed;
        logic [7:0] c;
        foreach (nm[k]) begin
            c = nm[k];
            if ($urandom_range(1) == 1) begin
                if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z)
                    c = c - CASE_OFFSET;
                else if (c >= CHAR_LOW_A - CASE_OFFSET && c <= CHAR_LOW_Z - CASE_OFFSET)
                    c = c + CASE_OFFSET;
            end
            if ($urandom_range(15) == 0)
                mixed.push_back(8'd0);
            mixed.push_back(c);
        end
        return mixed;
    endfunction

    // Builds a random name whose home slot is the given one: a random prefix,
    // then a final byte chosen so that the low hash bits land on the slot. The
    // final byte is kept nonzero and outside a to z so that folding leaves it alone.
    function automatic name_t name_at_slot(input int slot);
        name_t       nm;
        logic [31:0] h;
        logic [7:0]  c;
        int          d;
        int          cand;
        h = HASH_INIT;
        repeat ($urandom_range(1, 3)) begin
            c = 8'($urandom_range(1, 255));
            nm.push_back(c);
            h = fold_char(h, c);
        end
        d = (slot - int'((h * 32'd33) % 32'(MAP_DEPTH)) + MAP_DEPTH) % MAP_DEPTH;
        c = 8'(d);
        for (int k = 3; k >= 0; k--) begin
            cand = d + MAP_DEPTH * k;
            if (cand != 0 && (cand < int'(CHAR_LOW_A) || cand > int'(CHAR_LOW_Z)))
                c = 8'(cand);
        end
        nm.push_back(c);
        return nm;
    endfunction

    task automatic log_fault(input string what);
        err_count++;
        if (err_count <= 10)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Every strobed answer is taken at the edge that ends its cycle and is
    // compared with the oldest outstanding one.
    always @(posedge i_clk) begin : check_answers
        t_result_word want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (answer_q.size() == 0) begin
                log_fault($sformatf("answer with nothing outstanding: status %0d found_id %0d",
                                    o_result.status, o_result.found_id));
            end else begin
                want = answer_q.pop_front();
                answers_checked++;
                if (o_result.status !== want.status || o_result.found_id !== want.found_id)
                    log_fault($sformatf("status exp %0d got %0d, found_id exp %0d got %0d",
                                        want.status, o_result.status,
                                        want.found_id, o_result.found_id));
            end
        end
    end

    // Empty name, case folding, zero bytes inside a name and the bytes just
    // around the lower-case range, all in the domain bank.
    task automatic test_name_folding();
        name_t none;
        name_t plain;
        name_t rim;
        plain = to_name("node-a");
        rim   = '{8'hFF, 8'h01, 8'h60, 8'h7B, 8'h7A, 8'h61, 8'h5A, 8'h41};
        lookup_name(BANK_DOMAIN, none);
        add_name(BANK_DOMAIN, none, 5'd0, 8'd0);
        lookup_name(BANK_DOMAIN, none);
        add_name(BANK_DOMAIN, plain, 5'(ENTRY_DEPTH - 1), 8'hFF);
        lookup_name(BANK_DOMAIN, to_name("NODE-A"));
        plain.insert(2, 8'd0);
        lookup_name(BANK_DOMAIN, plain);
        add_name(BANK_DOMAIN, rim, 5'd1, 8'h80);
        lookup_name(BANK_DOMAIN, vary_case(rim));
        lookup_name(BANK_DOMAIN, to_name("node-b"));
    endtask

    // One name in the entity, level and unused banks, own id each, looked up in all
    // four; the unused bank answers not found and must leave every real bank alone.
    task automatic test_bank_select();
        name_t core;
        core = to_name("core");
        add_name(BANK_ENTITY, core, 5'd3, 8'h01);
        add_name(BANK_LEVEL, core, 5'(ENTRY_DEPTH - 1), 8'h02);
        add_name(BANK_UNUSED, core, 5'd4, 8'h03);
        lookup_name(BANK_DOMAIN, core);
        lookup_name(BANK_ENTITY, core);
        lookup_name(BANK_LEVEL, core);
        lookup_name(BANK_UNUSED, core);
    endtask

    // Re-inserting a name reuses its slot, whether the entry index stays or moves.
    task automatic test_entry_reuse();
        name_t core;
        core = to_name("core");
        add_name(BANK_ENTITY, core, 5'd3, 8'hA5);
        lookup_name(BANK_ENTITY, core);
        add_name(BANK_ENTITY, core, 5'd9, 8'h5A);
        lookup_name(BANK_ENTITY, core);
        add_name(BANK_ENTITY, to_name("Core"), 5'd3, 8'h00);
        lookup_name(BANK_ENTITY, core);
    endtask

    // Several names share the last home slot, so the chain wraps to slot 0; a
    // name homed at slot 0 then has to walk past the wrapped part of the chain.
    task automatic test_probe_chain();
        name_t chain[5];
        name_t late;
        foreach (chain[k])
            chain[k] = name_at_slot(MAP_DEPTH - 1);
        for (int k = 0; k < 4; k++)
            add_name(BANK_ENTITY, chain[k], 5'(10 + k), 8'(16 * k + 3));
        foreach (chain[k])
            lookup_name(BANK_ENTITY, chain[k]);
        late = name_at_slot(0);
        add_name(BANK_ENTITY, late, 5'd20, 8'h77);
        lookup_name(BANK_ENTITY, late);
    endtask

    // Fills every slot of the level bank with names homed on the empty slots,
    // using entries 1 and up only. Entry 0 is then referenced by no slot, so an
    // insert at entry 0 of a new name can claim nothing and reports the map full.
    // The fill is a long stretch with no gaps from the sender.
    task automatic test_full_bank();
        name_t last_nm;
        name_t spill;
        spill   = to_name("overflow-level");
        gaps_on = 1'b0;
        for (int s = 0; s < MAP_DEPTH; s++) begin
            if (slot_ref[BANK_LEVEL][s] == SLOT_EMPTY) begin
                last_nm = name_at_slot(s);
                add_name(BANK_LEVEL, last_nm, 5'($urandom_range(1, ENTRY_DEPTH - 1)),
                         8'($urandom_range(255)));
            end
        end
        gaps_on = 1'b1;
        add_name(BANK_LEVEL, spill, 5'd0, 8'h5A);
        // Its entry was written but no slot points at it: the lookup wraps.
        lookup_name(BANK_LEVEL, spill);
        lookup_name(BANK_LEVEL, last_nm);
        // A name already mapped still finds its own slot in a full map.
        add_name(BANK_LEVEL, last_nm, 5'd0, 8'hC3);
        lookup_name(BANK_LEVEL, last_nm);
    endtask

    // Mostly inserts and lookups of a shared pool of names, a quarter of which
    // collide on one home slot; the rest are unknown or empty names. Each request
    // goes to a random bank, now and then the unused one. A stretch in the
    // middle runs with no gaps from the sender.
    task automatic test_random_traffic();
        name_t      pool[POOL_SIZE];
        name_t      nm;
        int         base_cnt;
        int         n;
        logic [1:0] bank;
        for (int k = 0; k < POOL_SIZE; k++)
            pool[k] = (k < POOL_SIZE / 4) ? name_at_slot(5) : rand_name($urandom_range(1, 6));
        base_cnt = words_sent;
        while (words_sent - base_cnt < RANDOM_WORDS) begin
            n       = words_sent - base_cnt;
            gaps_on = (n < RANDOM_WORDS / 3 || n >= 2 * RANDOM_WORDS / 3);
            bank    = ($urandom_range(9) == 0) ? BANK_UNUSED : 2'($urandom_range(2));
            if ($urandom_range(99) < 85)
                nm = vary_case(pool[$urandom_range(POOL_SIZE - 1)]);
            else
                nm = rand_name($urandom_range(0, 4));
            send_name(1'($urandom_range(1)), bank, nm, 5'($urandom_range(31)),
                      8'($urandom_range(255)));
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        run_hash = HASH_INIT;
        foreach (slot_ref[b, s])
            slot_ref[b][s] = SLOT_EMPTY;
        foreach (ent_hash_m[b, e]) begin
            ent_hash_m[b][e] = '0;
            ent_id_m[b][e]   = '0;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_name_folding();
        wait_drain();
        test_bank_select();
        test_entry_reuse();
        wait_drain();
        test_probe_chain();
        test_full_bank();
        wait_drain();
        test_random_traffic();

        // Let the last answers out, then give a late or extra strobe time to show.
        wait_drain();
        repeat (16) @(posedge i_clk);
        if (answer_q.size() != 0)
            log_fault($sformatf("%0d answers never arrived", answer_q.size()));

        $display("covered %0d words and %0d answers: case folding, zero bytes, all banks",
                 words_sent, answers_checked);
        $display("plus the unused one, entry reuse, wrapped chains, a full bank; %0d mismatches",
                 err_count);
        if (err_count == 0)
            $display("name_hash_id_map_unit regression: pass");
        else
            $display("name_hash_id_map_unit regression: fail");
        $finish;
    end

    // Far beyond the slowest correct run, even with every lookup wrapping the map.
    initial begin
        #10_000_000;
        $display("name_hash_id_map_unit regression: fail");
        $finish;
    end

endmodule
